// ----- hw/rtl/bbcpu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package bbcpu_pkg;

  typedef enum logic [5:0] {
    OPC_MOV  = 6'd0,
    OPC_LW   = 6'd1,
    OPC_LH   = 6'd2,
    OPC_LHSX = 6'd3,
    OPC_LB   = 6'd4,
    OPC_LBSX = 6'd5,
    OPC_SW   = 6'd6,
    OPC_SH   = 6'd7,
    OPC_SB   = 6'd8,
    OPC_ADD  = 6'd9,
    OPC_ADC  = 6'd10,
    OPC_SUB  = 6'd11,
    OPC_SBB  = 6'd12,
    OPC_NEG  = 6'd13,
    OPC_CMP  = 6'd14,
    OPC_AND  = 6'd15,
    OPC_OR   = 6'd16,
    OPC_XOR  = 6'd17,
    OPC_NOT  = 6'd18,
    OPC_TEST = 6'd19,
    OPC_SHL  = 6'd20,
    OPC_SHR  = 6'd21,
    OPC_SAR  = 6'd22,
    OPC_JMP  = 6'd23
  } opc_t;

  localparam logic [3:0] FLAGS_REG = 4'd15;
  localparam logic [3:0] RET_REG   = 4'd14;
  localparam int         HALT_BIT  = 8;

  // Tick phases: four fetch bytes, execute, then the later data bytes.
  typedef enum logic [2:0] {
    PH_FETCH0 = 3'd0,
    PH_FETCH1 = 3'd1,
    PH_FETCH2 = 3'd2,
    PH_FETCH3 = 3'd3,
    PH_EXEC   = 3'd4,
    PH_MORE1  = 3'd5,
    PH_MORE2  = 3'd6,
    PH_MORE3  = 3'd7
  } phase_t;

  // Jump condition codes held in the destination field of a jump.
  localparam logic [3:0] JC_ALWAYS = 4'd0;
  localparam logic [3:0] JC_CALL   = 4'd1;
  localparam logic [3:0] JC_C      = 4'd2;
  localparam logic [3:0] JC_NC     = 4'd3;
  localparam logic [3:0] JC_Z      = 4'd4;
  localparam logic [3:0] JC_NZ     = 4'd5;
  localparam logic [3:0] JC_S      = 4'd6;
  localparam logic [3:0] JC_NS     = 4'd7;
  localparam logic [3:0] JC_O      = 4'd8;
  localparam logic [3:0] JC_NO     = 4'd9;
  localparam logic [3:0] JC_A      = 4'd10;
  localparam logic [3:0] JC_BE     = 4'd11;
  localparam logic [3:0] JC_L      = 4'd12;
  localparam logic [3:0] JC_GE     = 4'd13;
  localparam logic [3:0] JC_G      = 4'd14;
  localparam logic [3:0] JC_LE     = 4'd15;

  localparam logic [0:0] CFG_START_ADDRESS = 1'd0;

  // Result word of one tick.
  typedef struct packed {
    logic        read_enable;
    logic [31:0] read_address;
    logic        write_enable;
    logic [31:0] write_address;
    logic [7:0]  write_byte;
    logic        instruction_done;
    logic        halted;
  } res_t;

  function automatic logic is_load(input logic [5:0] op);
    return op == OPC_LW || op == OPC_LH || op == OPC_LHSX || op == OPC_LB || op == OPC_LBSX;
  endfunction

  function automatic logic is_shift(input logic [5:0] op);
    return op == OPC_SHL || op == OPC_SHR || op == OPC_SAR;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/bbcpu_alu.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Arithmetic, logic and shift unit with the four condition flags.
module bbcpu_alu (
  input  wire logic [5:0]  op,
  input  wire logic [31:0] a_in,
  input  wire logic [31:0] d_in,
  input  wire logic        cin,
  output logic [31:0]      res,
  output logic [3:0]       flags
);
  logic [32:0] sum;
  logic [32:0] rhs;
  logic [31:0] a;
  logic        bin;
  logic        carry;
  logic        ov;
  logic [4:0]  sh;

  always_comb begin
    sh    = d_in[4:0];
    a     = a_in;
    bin   = 1'b0;
    carry = 1'b0;
    ov    = 1'b0;
    sum   = '0;
    rhs   = '0;
    res   = '0;
    unique case (op) inside
      bbcpu_pkg::OPC_ADD, bbcpu_pkg::OPC_ADC: begin
        sum   = {1'b0, a} + {1'b0, d_in} +
                {32'd0, (op == bbcpu_pkg::OPC_ADC) & cin};
        res   = sum[31:0];
        carry = sum[32];
        ov    = (a[31] ^ res[31]) & (d_in[31] ^ res[31]);
      end
      bbcpu_pkg::OPC_SUB, bbcpu_pkg::OPC_SBB, bbcpu_pkg::OPC_NEG, bbcpu_pkg::OPC_CMP: begin
        bin = (op == bbcpu_pkg::OPC_SBB) & cin;
        if (op == bbcpu_pkg::OPC_NEG) begin
          a = '0;
        end
        // Borrow comes from the 33-bit difference.
        rhs   = {1'b0, d_in} + {32'd0, bin};
        sum   = {1'b0, a} - rhs;
        res   = sum[31:0];
        carry = sum[32];
        ov    = (a[31] ^ d_in[31]) & (a[31] ^ res[31]);
      end
      bbcpu_pkg::OPC_AND, bbcpu_pkg::OPC_TEST: res = a & d_in;
      bbcpu_pkg::OPC_OR:   res = a | d_in;
      bbcpu_pkg::OPC_XOR:  res = a ^ d_in;
      bbcpu_pkg::OPC_NOT:  res = ~d_in;
      bbcpu_pkg::OPC_SHL:  res = a << sh;
      bbcpu_pkg::OPC_SHR:  res = a >> sh;
      bbcpu_pkg::OPC_SAR:  res = $unsigned($signed(a) >>> sh);
      default:             res = '0;
    endcase
    flags = {ov, res[31], res == 32'd0, carry};
  end
endmodule
`default_nettype wire

// ----- hw/rtl/byte_bus_multicycle_cpu_core_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Channel | Ports                                      | Direction
// in      | in_valid, in_ready, in_read_byte           | word in, one bus tick
// out     | out_valid, out_ready, out_* result fields  | word out per tick
// cfg     | psel, penable, pwrite, paddr, pwdata ...   | start address register
// Each input word is one tick; one word a cycle is sustained while the result
// register is not stalled by out_ready.
// A one-word output register holds the result; input is taken while it is
// empty or being drained this cycle.
// rst_n is synchronous; after reset the instruction pointer is the start address.
module byte_bus_multicycle_cpu_core_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_read_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_read_enable,
  output logic [31:0]      out_read_address,
  output logic             out_write_enable,
  output logic [31:0]      out_write_address,
  output logic [7:0]       out_write_byte,
  output logic             out_instruction_done,
  output logic             out_halted,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [0:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  logic [31:0] start_r;
  logic [31:0] ip_r, ip_nxt;
  logic [31:0] rf_r [16];
  logic [31:0] rf_nxt [16];
  logic [7:0]  ib_r [4];
  logic [7:0]  ib_nxt [4];
  bbcpu_pkg::phase_t ph_r, ph_nxt;
  logic [31:0] ea_r, ea_nxt;
  logic        fresh_r;
  logic        ov_r;
  bbcpu_pkg::res_t res_r, res_nxt;

  logic        fire, cfg_wr;
  logic [7:0]  b;
  logic [5:0]  op, nop;
  logic [3:0]  dest;
  logic [31:0] alu_res, dval, opnd, tgt, v;
  logic [3:0]  alu_fl;
  logic [19:0] imm20;
  logic [1:0]  n;
  logic [4:0]  shb;
  logic        take, last, c, z, s, o;

  assign pready   = 1'b1;
  assign prdata   = start_r;
  assign cfg_wr   = psel & penable & pwrite & (paddr == bbcpu_pkg::CFG_START_ADDRESS);
  assign in_ready = !ov_r || out_ready;
  assign fire     = in_valid & in_ready;
  assign out_valid = ov_r;
  assign b    = in_read_byte;
  assign op   = ib_r[0][7:2];
  assign dest = ib_r[1][7:4];
  assign dval = rf_r[dest];

  bbcpu_alu u_alu (
    .op(op), .a_in(dval), .d_in(ea_r), .cin(rf_r[bbcpu_pkg::FLAGS_REG][0]),
    .res(alu_res), .flags(alu_fl)
  );

  // Next state of the core for one tick.
  always_comb begin
    ip_nxt = ip_r;
    rf_nxt = rf_r;
    ib_nxt = ib_r;
    ph_nxt = ph_r;
    ea_nxt = ea_r;
    res_nxt = '0;
    opnd = '0;
    imm20 = '0;
    tgt = '0;
    v = '0;
    take = 1'b0;
    last = 1'b1;
    nop = '0;
    n = ph_r[1:0];
    shb = {n, 3'd0};
    c = rf_r[bbcpu_pkg::FLAGS_REG][0];
    z = rf_r[bbcpu_pkg::FLAGS_REG][1];
    s = rf_r[bbcpu_pkg::FLAGS_REG][2];
    o = rf_r[bbcpu_pkg::FLAGS_REG][3];
    if (rf_r[bbcpu_pkg::FLAGS_REG][bbcpu_pkg::HALT_BIT]) begin
      res_nxt.halted = 1'b1;
    end else begin
      unique case (ph_r) inside
        bbcpu_pkg::PH_FETCH0: begin
          ib_nxt[0] = b;
          ip_nxt = ip_r + 32'd1;
          ph_nxt = bbcpu_pkg::PH_FETCH1;
        end
        bbcpu_pkg::PH_FETCH2: begin
          ib_nxt[2] = b;
          ip_nxt = ip_r + 32'd1;
          ph_nxt = bbcpu_pkg::PH_FETCH3;
        end
        bbcpu_pkg::PH_FETCH1, bbcpu_pkg::PH_FETCH3: begin
          if (ph_r == bbcpu_pkg::PH_FETCH1) ib_nxt[1] = b;
          else ib_nxt[3] = b;
          ip_nxt = ip_r + 32'd1;
          if (ph_r == bbcpu_pkg::PH_FETCH1 && ib_r[0][0]) begin
            ph_nxt = bbcpu_pkg::PH_FETCH2;
          end else begin
            ph_nxt = bbcpu_pkg::PH_EXEC;
            // Latch the operand once the instruction is complete.
            if (ib_nxt[0][0]) begin
              if (ib_nxt[0][1]) begin
                imm20 = {ib_nxt[3], ib_nxt[2], ib_nxt[1][3:0]};
                opnd = {12'd0, imm20};
                if (bbcpu_pkg::is_shift(ib_nxt[0][7:2])) opnd = opnd + 32'd1;
                if (ib_nxt[0][7:2] == bbcpu_pkg::OPC_JMP) opnd = {{11{imm20[19]}}, imm20, 1'b0};
              end else begin
                opnd = rf_r[ib_nxt[1][3:0]] + {{16{ib_nxt[3][7]}}, ib_nxt[3], ib_nxt[2]};
              end
            end else if (ib_nxt[0][1]) begin
              opnd = {28'd0, ib_nxt[1][3:0]};
              if (bbcpu_pkg::is_shift(ib_nxt[0][7:2])) opnd = opnd + 32'd1;
              if (ib_nxt[0][7:2] == bbcpu_pkg::OPC_JMP)
                opnd = {{27{ib_nxt[1][3]}}, ib_nxt[1][3:0], 1'b0};
            end else begin
              opnd = rf_r[ib_nxt[1][3:0]];
            end
            ea_nxt = opnd;
          end
        end
        bbcpu_pkg::PH_EXEC: begin
          ph_nxt = bbcpu_pkg::PH_FETCH0;
          res_nxt.instruction_done = 1'b1;
          unique case (op) inside
            bbcpu_pkg::OPC_MOV: rf_nxt[dest] = ea_r;
            bbcpu_pkg::OPC_LW, bbcpu_pkg::OPC_LH, bbcpu_pkg::OPC_LHSX: begin
              rf_nxt[dest] = {24'd0, b};
              ph_nxt = bbcpu_pkg::PH_MORE1;
              res_nxt.instruction_done = 1'b0;
            end
            bbcpu_pkg::OPC_LB:   rf_nxt[dest] = {24'd0, b};
            bbcpu_pkg::OPC_LBSX: rf_nxt[dest] = {{24{b[7]}}, b};
            bbcpu_pkg::OPC_SW, bbcpu_pkg::OPC_SH, bbcpu_pkg::OPC_SB: begin
              res_nxt.write_enable = 1'b1;
              res_nxt.write_address = ea_r;
              res_nxt.write_byte = dval[7:0];
              if (op != bbcpu_pkg::OPC_SB) begin
                ph_nxt = bbcpu_pkg::PH_MORE1;
                res_nxt.instruction_done = 1'b0;
              end
            end
            bbcpu_pkg::OPC_ADD, bbcpu_pkg::OPC_ADC, bbcpu_pkg::OPC_SUB, bbcpu_pkg::OPC_SBB,
            bbcpu_pkg::OPC_NEG, bbcpu_pkg::OPC_CMP, bbcpu_pkg::OPC_AND, bbcpu_pkg::OPC_OR,
            bbcpu_pkg::OPC_XOR, bbcpu_pkg::OPC_NOT, bbcpu_pkg::OPC_TEST, bbcpu_pkg::OPC_SHL,
            bbcpu_pkg::OPC_SHR, bbcpu_pkg::OPC_SAR: begin
              if (op != bbcpu_pkg::OPC_CMP && op != bbcpu_pkg::OPC_TEST) rf_nxt[dest] = alu_res;
              // Flag bits are replaced after the result lands.
              rf_nxt[bbcpu_pkg::FLAGS_REG] = {rf_nxt[bbcpu_pkg::FLAGS_REG][31:4], alu_fl};
            end
            bbcpu_pkg::OPC_JMP: begin
              tgt = ib_r[0][1] ? ip_r + ea_r : ea_r;
              unique case (dest)
                bbcpu_pkg::JC_ALWAYS: take = 1'b1;
                bbcpu_pkg::JC_CALL: begin
                  take = 1'b1;
                  rf_nxt[bbcpu_pkg::RET_REG] = ip_r;
                end
                bbcpu_pkg::JC_C:  take = c;
                bbcpu_pkg::JC_NC: take = !c;
                bbcpu_pkg::JC_Z:  take = z;
                bbcpu_pkg::JC_NZ: take = !z;
                bbcpu_pkg::JC_S:  take = s;
                bbcpu_pkg::JC_NS: take = !s;
                bbcpu_pkg::JC_O:  take = o;
                bbcpu_pkg::JC_NO: take = !o;
                bbcpu_pkg::JC_A:  take = !c && !z;
                bbcpu_pkg::JC_BE: take = c || z;
                bbcpu_pkg::JC_L:  take = s != o;
                bbcpu_pkg::JC_GE: take = s == o;
                bbcpu_pkg::JC_G:  take = !z && (s == o);
                default: take = z || (s != o);
              endcase
              if (take) ip_nxt = tgt;
            end
            default: ;
          endcase
        end
        default: begin
          // Continuation bytes of half and word accesses.
          last = (op == bbcpu_pkg::OPC_LW || op == bbcpu_pkg::OPC_SW) ? (n == 2'd3) : 1'b1;
          if (op == bbcpu_pkg::OPC_LW ||
              (n == 2'd1 && (op == bbcpu_pkg::OPC_LH || op == bbcpu_pkg::OPC_LHSX))) begin
            v = ({24'd0, b} << shb) | (dval & ~(32'hffffffff << shb));
            if (op == bbcpu_pkg::OPC_LHSX) v = {{16{v[15]}}, v[15:0]};
            rf_nxt[dest] = v;
          end else if (op == bbcpu_pkg::OPC_SW || (n == 2'd1 && op == bbcpu_pkg::OPC_SH)) begin
            res_nxt.write_enable = 1'b1;
            res_nxt.write_address = ea_r + {30'd0, n};
            res_nxt.write_byte = 8'(dval >> shb);
          end else begin
            last = 1'b1;
          end
          if (last) begin
            ph_nxt = bbcpu_pkg::PH_FETCH0;
            res_nxt.instruction_done = 1'b1;
          end else begin
            ph_nxt = bbcpu_pkg::phase_t'(ph_r + 3'd1);
          end
        end
      endcase
      nop = ib_nxt[0][7:2];
      if (rf_nxt[bbcpu_pkg::FLAGS_REG][bbcpu_pkg::HALT_BIT]) begin
        res_nxt.halted = 1'b1;
      end else if (ph_nxt < bbcpu_pkg::PH_EXEC) begin
        res_nxt.read_enable = 1'b1;
        res_nxt.read_address = ip_nxt;
      end else if (bbcpu_pkg::is_load(nop)) begin
        res_nxt.read_enable = 1'b1;
        res_nxt.read_address = ea_nxt + {30'd0, ph_nxt[1:0]};
      end
    end
  end

  // Control state and architectural state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_r <= '0;
      ip_r    <= '0;
      ph_r    <= bbcpu_pkg::PH_FETCH0;
      ea_r    <= '0;
      fresh_r <= 1'b1;
      ov_r    <= 1'b0;
      for (int i = 0; i < 16; i++) rf_r[i] <= '0;
      for (int i = 0; i < 4; i++) ib_r[i] <= '0;
    end else begin
      if (fire) begin
        rf_r <= rf_nxt;
        ib_r <= ib_nxt;
        ph_r <= ph_nxt;
        ea_r <= ea_nxt;
        fresh_r <= 1'b0;
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
      if (cfg_wr) begin
        start_r <= pwdata;
      end
      // The start address also moves the pointer until the first tick.
      if (cfg_wr && fresh_r) begin
        ip_r <= pwdata;
      end else if (fire) begin
        ip_r <= ip_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) res_r <= res_nxt;
  end

  assign out_read_enable      = res_r.read_enable;
  assign out_read_address     = res_r.read_address;
  assign out_write_enable     = res_r.write_enable;
  assign out_write_address    = res_r.write_address;
  assign out_write_byte       = res_r.write_byte;
  assign out_instruction_done = res_r.instruction_done;
  assign out_halted           = res_r.halted;

`ifndef SYNTHESIS
  // A halted core never reports a store.
  a_halt_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_halted |-> !out_write_enable)
    else $error("store while halted");
  // Once halted, the instruction pointer holds.
  a_halt_ip: assert property (@(posedge clk) disable iff (!rst_n)
    rf_r[bbcpu_pkg::FLAGS_REG][bbcpu_pkg::HALT_BIT] && !cfg_wr |=> $stable(ip_r))
    else $error("ip moved while halted");
  // A full output register that is not drained blocks input.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken over a stalled result");
`endif
endmodule
`default_nettype wire

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import bbcpu_pkg::*;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_read_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_read_enable;
  logic [31:0] out_read_address;
  logic        out_write_enable;
  logic [31:0] out_write_address;
  logic [7:0]  out_write_byte;
  logic        out_instruction_done;
  logic        out_halted;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [0:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  byte_bus_multicycle_cpu_core_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_read_byte(in_read_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_read_enable(out_read_enable), .out_read_address(out_read_address),
    .out_write_enable(out_write_enable), .out_write_address(out_write_address),
    .out_write_byte(out_write_byte), .out_instruction_done(out_instruction_done),
    .out_halted(out_halted),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #5 clk = ~clk;

  // Bytes waiting to be offered and tick results still to arrive.
  logic [7:0] bus_byte_q[$];
  res_t       tick_q[$];
  int         errors = 0;
  int         send_idle_pct = 0;
  int         recv_stall_pct = 0;
  bit         recv_hold = 1'b0;

  // Shadow of the core state.
  logic [31:0] cpu_start;
  logic [31:0] cpu_ip;
  logic [31:0] cpu_regs[16];
  logic [7:0]  cpu_ibytes[4];
  logic [2:0]  cpu_phase;
  logic [31:0] cpu_ea;
  bit          cpu_fresh;
  logic [7:0]  bus_mem[logic [31:0]];
  logic [31:0] cur_ins;
  logic [31:0] prog_q[$];

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
    $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic bit is_mem_read(input logic [5:0] op);
    return op == OPC_LW || op == OPC_LH || op == OPC_LHSX || op == OPC_LB || op == OPC_LBSX;
  endfunction

  function automatic bit is_shift_op(input logic [5:0] op);
    return op == OPC_SHL || op == OPC_SHR || op == OPC_SAR;
  endfunction

  // Operand worked out when the last instruction byte arrives.
  function automatic logic [31:0] operand_of();
    logic [5:0]  op;
    logic [31:0] d;
    logic [15:0] disp;
    op = cpu_ibytes[0][7:2];
    if (cpu_ibytes[0][0]) begin
      if (cpu_ibytes[0][1]) begin
        d = {12'd0, cpu_ibytes[3], cpu_ibytes[2], cpu_ibytes[1][3:0]};
        if (is_shift_op(op)) d = d + 32'd1;
        if (op == OPC_JMP) d = {{12{d[19]}}, d[19:0]} << 1;
      end else begin
        disp = {cpu_ibytes[3], cpu_ibytes[2]};
        d = cpu_regs[cpu_ibytes[1][3:0]] + {{16{disp[15]}}, disp};
      end
    end else begin
      if (cpu_ibytes[0][1]) begin
        d = {28'd0, cpu_ibytes[1][3:0]};
        if (is_shift_op(op)) d = d + 32'd1;
        if (op == OPC_JMP) d = {{28{d[3]}}, d[3:0]} << 1;
      end else begin
        d = cpu_regs[cpu_ibytes[1][3:0]];
      end
    end
    return d;
  endfunction

  function automatic void put_flags(input logic [3:0] f);
    cpu_regs[FLAGS_REG] = {cpu_regs[FLAGS_REG][31:4], f};
  endfunction

  // Execute phase of arithmetic, logic and jump instructions.
  function automatic void exec_alu(input logic [5:0] op, input logic [3:0] dst,
                                   input logic [31:0] d);
    logic [31:0] a, r;
    logic [32:0] s;
    logic        cin, cy, ov, take, c, z, sg, o;
    logic [31:0] tgt;
    a = cpu_regs[dst];
    cin = cpu_regs[FLAGS_REG][0];
    if (op >= OPC_ADD && op <= OPC_CMP) begin
      if (op == OPC_ADD || op == OPC_ADC) begin
        s = {1'b0, a} + {1'b0, d} + {32'd0, (op == OPC_ADC) ? cin : 1'b0};
        r = s[31:0];
        cy = s[32];
        ov = (a[31] ^ r[31]) & (d[31] ^ r[31]);
      end else begin
        if (op == OPC_NEG) a = '0;
        s = {1'b0, d} + {32'd0, (op == OPC_SBB) ? cin : 1'b0};
        r = a - s[31:0];
        cy = {1'b0, a} < s;
        ov = (a[31] ^ d[31]) & (a[31] ^ r[31]);
      end
      if (op != OPC_CMP) cpu_regs[dst] = r;
      put_flags({ov, r[31], r == 32'd0, cy});
    end else if (op >= OPC_AND && op <= OPC_SAR) begin
      case (op) inside
        OPC_AND, OPC_TEST: r = a & d;
        OPC_OR:  r = a | d;
        OPC_XOR: r = a ^ d;
        OPC_NOT: r = ~d;
        OPC_SHL: r = a << d[4:0];
        OPC_SHR: r = a >> d[4:0];
        default: r = $signed(a) >>> d[4:0];
      endcase
      if (op != OPC_TEST) cpu_regs[dst] = r;
      put_flags({1'b0, r[31], r == 32'd0, 1'b0});
    end else if (op == OPC_JMP) begin
      {o, sg, z, c} = cpu_regs[FLAGS_REG][3:0];
      tgt = cpu_ibytes[0][1] ? cpu_ip + d : d;
      case (dst)
        JC_ALWAYS: take = 1'b1;
        JC_CALL: begin
          take = 1'b1;
          cpu_regs[RET_REG] = cpu_ip;
        end
        JC_C:  take = c;
        JC_NC: take = !c;
        JC_Z:  take = z;
        JC_NZ: take = !z;
        JC_S:  take = sg;
        JC_NS: take = !sg;
        JC_O:  take = o;
        JC_NO: take = !o;
        JC_A:  take = !c && !z;
        JC_BE: take = c || z;
        JC_L:  take = sg != o;
        JC_GE: take = sg == o;
        JC_G:  take = !z && sg == o;
        default: take = z || sg != o;
      endcase
      if (take) cpu_ip = tgt;
    end
  endfunction

  // One bus tick of the core: consumes a byte and returns the tick result.
  function automatic res_t cpu_tick(input logic [7:0] b);
    res_t        r;
    logic [5:0]  op;
    logic [3:0]  dst;
    logic [31:0] d, v;
    int          n;
    bit          last;
    r = '0;
    op = cpu_ibytes[0][7:2];
    dst = cpu_ibytes[1][7:4];
    d = cpu_ea;
    if (cpu_regs[FLAGS_REG][HALT_BIT]) begin
      r.halted = 1'b1;
      return r;
    end
    cpu_fresh = 1'b0;
    case (cpu_phase)
      PH_FETCH0: begin
        cpu_ibytes[0] = b; cpu_ip++; cpu_phase = PH_FETCH1;
      end
      PH_FETCH1: begin
        cpu_ibytes[1] = b; cpu_ip++;
        if (cpu_ibytes[0][0]) cpu_phase = PH_FETCH2;
        else begin
          cpu_phase = PH_EXEC;
          cpu_ea = operand_of();
        end
      end
      PH_FETCH2: begin
        cpu_ibytes[2] = b; cpu_ip++; cpu_phase = PH_FETCH3;
      end
      PH_FETCH3: begin
        cpu_ibytes[3] = b; cpu_ip++; cpu_phase = PH_EXEC;
        cpu_ea = operand_of();
      end
      PH_EXEC: begin
        cpu_phase = PH_FETCH0;
        r.instruction_done = 1'b1;
        case (op) inside
          OPC_MOV: cpu_regs[dst] = d;
          OPC_LW, OPC_LH, OPC_LHSX: begin
            cpu_regs[dst] = {24'd0, b};
            cpu_phase = PH_MORE1;
            r.instruction_done = 1'b0;
          end
          OPC_LB:   cpu_regs[dst] = {24'd0, b};
          OPC_LBSX: cpu_regs[dst] = {{24{b[7]}}, b};
          OPC_SW, OPC_SH, OPC_SB: begin
            r.write_enable = 1'b1;
            r.write_address = d;
            r.write_byte = cpu_regs[dst][7:0];
            if (op != OPC_SB) begin
              cpu_phase = PH_MORE1;
              r.instruction_done = 1'b0;
            end
          end
          default: exec_alu(op, dst, d);
        endcase
      end
      default: begin
        // Later bytes of half and word loads and stores.
        n = cpu_phase - PH_EXEC;
        last = (op == OPC_LW || op == OPC_SW) ? (n == 3) : 1'b1;
        if (op == OPC_LW || (n == 1 && (op == OPC_LH || op == OPC_LHSX))) begin
          v = ({24'd0, b} << (8 * n)) | (cpu_regs[dst] & (32'hffffffff >> (32 - 8 * n)));
          if (op == OPC_LHSX) v = {{16{v[15]}}, v[15:0]};
          cpu_regs[dst] = v;
        end else if (op == OPC_SW || (n == 1 && op == OPC_SH)) begin
          r.write_enable = 1'b1;
          r.write_address = d + 32'(n);
          r.write_byte = 8'(cpu_regs[dst] >> (8 * n));
        end else begin
          last = 1'b1;
        end
        if (last) begin
          cpu_phase = PH_FETCH0;
          r.instruction_done = 1'b1;
        end else begin
          cpu_phase++;
        end
      end
    endcase
    op = cpu_ibytes[0][7:2];
    if (cpu_regs[FLAGS_REG][HALT_BIT]) begin
      r.halted = 1'b1;
    end else if (cpu_phase < PH_EXEC) begin
      r.read_enable = 1'b1;
      r.read_address = cpu_ip;
    end else if (is_mem_read(op)) begin
      r.read_enable = 1'b1;
      r.read_address = cpu_ea + {29'd0, cpu_phase - PH_EXEC};
    end
    return r;
  endfunction

  function automatic logic [31:0] encode(input logic [5:0] op, input bit imf, input bit lng,
                                         input logic [3:0] dst, input logic [3:0] src,
                                         input logic [15:0] ext);
    return {ext, dst, src, op, imf, lng};
  endfunction

  // Random instruction; the flags register is only a target of compare,
  // test and jumps so that the core does not stop early.
  function automatic logic [31:0] random_instruction();
    logic [5:0]  op;
    logic [3:0]  dst;
    logic [15:0] ext;
    bit          imf, lng;
    if ($urandom_range(0, 99) < 4) op = 6'($urandom_range(24, 63));
    else op = 6'($urandom_range(0, 23));
    imf = 1'($urandom_range(0, 1));
    lng = 1'($urandom_range(0, 1));
    dst = 4'($urandom_range(0, 14));
    ext = 16'($urandom);
    if (op == OPC_JMP || ((op == OPC_CMP || op == OPC_TEST) && $urandom_range(0, 3) == 0))
      dst = 4'($urandom_range(0, 15));
    // Keep most memory traffic in a small window so loads see earlier stores.
    if (op >= OPC_LW && op <= OPC_SB && $urandom_range(0, 9) < 7) begin
      imf = 1'b1;
      lng = 1'b1;
      ext = 16'($urandom_range(0, 7));
    end
    return encode(op, imf, lng, dst, 4'($urandom_range(0, 15)), ext);
  endfunction

  // Choose the byte the bus returns for the pending read, predict the tick.
  task automatic make_ticks(input int count);
    logic [7:0]  b;
    logic [31:0] addr;
    res_t        r;
    repeat (count) begin
      b = 8'($urandom);
      if (!cpu_regs[FLAGS_REG][HALT_BIT]) begin
        if (cpu_phase < PH_EXEC) begin
          if (cpu_phase == PH_FETCH0)
            cur_ins = (prog_q.size() != 0) ? prog_q.pop_front() : random_instruction();
          b = cur_ins[8 * cpu_phase +: 8];
        end else if (is_mem_read(cpu_ibytes[0][7:2])) begin
          addr = cpu_ea + {29'd0, cpu_phase - PH_EXEC};
          if (bus_mem.exists(addr)) b = bus_mem[addr];
          else bus_mem[addr] = b;
        end
      end
      r = cpu_tick(b);
      if (r.write_enable) bus_mem[r.write_address] = r.write_byte;
      bus_byte_q.push_back(b);
      tick_q.push_back(r);
    end
  endtask

  task automatic write_start(input logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; paddr = CFG_START_ADDRESS; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    cpu_start = value;
    if (cpu_fresh) cpu_ip = value;
  endtask

  task automatic drain();
    while (bus_byte_q.size() != 0 || tick_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Driver: offers the next byte, holding it until it is taken.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_ready) begin
      if (bus_byte_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_read_byte <= bus_byte_q.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Monitor: compares every accepted word with the oldest predicted tick.
  always @(posedge clk) begin : monitor
    res_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (tick_q.size() == 0) begin
          report("unexpected word", 32'd0, 32'd0);
        end else begin
          want = tick_q.pop_front();
          if (out_read_enable !== want.read_enable)
            report("read_enable", {31'd0, out_read_enable}, {31'd0, want.read_enable});
          if (out_read_address !== want.read_address)
            report("read_address", out_read_address, want.read_address);
          if (out_write_enable !== want.write_enable)
            report("write_enable", {31'd0, out_write_enable}, {31'd0, want.write_enable});
          if (out_write_address !== want.write_address)
            report("write_address", out_write_address, want.write_address);
          if (out_write_byte !== want.write_byte)
            report("write_byte", {24'd0, out_write_byte}, {24'd0, want.write_byte});
          if (out_instruction_done !== want.instruction_done)
            report("instruction_done", {31'd0, out_instruction_done},
                   {31'd0, want.instruction_done});
          if (out_halted !== want.halted)
            report("halted", {31'd0, out_halted}, {31'd0, want.halted});
        end
      end
      out_ready <= !recv_hold && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Long receiver hold-off; the calling process waits while it lasts.
  task automatic hold_receiver(input int cycles);
    @(negedge clk);
    recv_hold = 1'b1;
    repeat (cycles) @(negedge clk);
    recv_hold = 1'b0;
  endtask

  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    cpu_start = '0;
    cpu_ip = '0;
    foreach (cpu_regs[i]) cpu_regs[i] = '0;
    foreach (cpu_ibytes[i]) cpu_ibytes[i] = '0;
    cpu_phase = PH_FETCH0;
    cpu_ea = '0;
    cpu_fresh = 1'b1;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Start address written at both extremes, then a random one that sticks.
    write_start(32'hffffffff);
    write_start(32'h0);
    write_start($urandom);

    // Directed program: every operation but LB, each operand form and the special cases.
    prog_q.push_back(encode(OPC_MOV, 1'b1, 1'b1, 4'd1, 4'hf, 16'hffff));
    prog_q.push_back(encode(OPC_MOV, 1'b1, 1'b0, 4'd2, 4'h7, 16'h0));
    prog_q.push_back(encode(OPC_ADD, 1'b0, 1'b0, 4'd1, 4'd2, 16'h0));
    prog_q.push_back(encode(OPC_ADC, 1'b0, 1'b1, 4'd3, 4'd1, 16'h8000));
    prog_q.push_back(encode(OPC_SUB, 1'b1, 1'b0, 4'd2, 4'hf, 16'h0));
    prog_q.push_back(encode(OPC_SBB, 1'b0, 1'b0, 4'd4, 4'd1, 16'h0));
    prog_q.push_back(encode(OPC_NEG, 1'b0, 1'b0, 4'd5, 4'd1, 16'h0));
    prog_q.push_back(encode(OPC_CMP, 1'b0, 1'b0, 4'd1, 4'd2, 16'h0));
    prog_q.push_back(encode(OPC_AND, 1'b1, 1'b0, FLAGS_REG, 4'd3, 16'h0));
    prog_q.push_back(encode(OPC_OR, 1'b0, 1'b0, 4'd6, 4'd1, 16'h0));
    prog_q.push_back(encode(OPC_XOR, 1'b0, 1'b0, 4'd7, 4'd6, 16'h0));
    prog_q.push_back(encode(OPC_NOT, 1'b0, 1'b0, 4'd8, 4'd1, 16'h0));
    prog_q.push_back(encode(OPC_TEST, 1'b0, 1'b0, 4'd1, 4'd2, 16'h0));
    prog_q.push_back(encode(OPC_SHL, 1'b1, 1'b0, 4'd1, 4'hf, 16'h0));
    prog_q.push_back(encode(OPC_SHR, 1'b1, 1'b1, 4'd1, 4'hf, 16'hffff));
    prog_q.push_back(encode(OPC_SAR, 1'b1, 1'b0, 4'd8, 4'h0, 16'h0));
    prog_q.push_back(encode(OPC_SW, 1'b1, 1'b1, 4'd8, 4'h0, 16'h1));
    prog_q.push_back(encode(OPC_SH, 1'b0, 1'b1, 4'd7, 4'd0, 16'h14));
    prog_q.push_back(encode(OPC_SB, 1'b1, 1'b0, 4'd6, 4'h3, 16'h0));
    prog_q.push_back(encode(OPC_LW, 1'b1, 1'b1, 4'd9, 4'h0, 16'h1));
    prog_q.push_back(encode(OPC_LHSX, 1'b1, 1'b1, 4'd11, 4'h2, 16'h1));
    prog_q.push_back(encode(OPC_LH, 1'b0, 1'b1, 4'd10, 4'd0, 16'h14));
    prog_q.push_back(encode(OPC_LBSX, 1'b1, 1'b1, 4'd13, 4'h3, 16'h1));
    prog_q.push_back(encode(OPC_JMP, 1'b1, 1'b0, JC_CALL, 4'h1, 16'h0));
    prog_q.push_back(encode(6'd63, 1'b0, 1'b0, 4'd0, 4'd0, 16'h0));

    // Phases of flow control, the second to fourth each followed by a start address write.
    make_ticks(150);
    drain();
    send_idle_pct = 54;
    make_ticks(150);
    drain();
    write_start(32'hffffffff);
    send_idle_pct = 0;
    recv_stall_pct = 54;
    make_ticks(150);
    drain();
    write_start($urandom);
    send_idle_pct = 37;
    recv_stall_pct = 37;
    make_ticks(150);
    drain();
    write_start(32'h0);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    make_ticks(150);
    hold_receiver(300);

    // Set the halt flag and run a few ticks past it.
    prog_q.push_back(encode(OPC_LB, 1'b1, 1'b1, 4'd12, 4'h0, 16'h1));
    prog_q.push_back(encode(OPC_MOV, 1'b1, 1'b1, FLAGS_REG, 4'h0, 16'h10));
    while (!cpu_regs[FLAGS_REG][HALT_BIT]) make_ticks(1);
    make_ticks(10);

    drain();
    repeat (10) @(negedge clk);
    if (errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
